### rtl/assert_macros.svh
// Assertion helpers used by clipped_rect_fill_writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock, off while reset is held.
`define ASSERT_CLK(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// Same, for a property that must also hold in the cycle reset goes away.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
    label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/crfw_pkg.sv
package crfw_pkg;

    localparam int MAX_SCREEN_DIM = 8192;
    localparam int COL_W          = $clog2(MAX_SCREEN_DIM);
    localparam int END_W          = COL_W + 1;
    localparam int DIM_W          = 14;
    localparam int ADDR_W         = 32;
    localparam int PIX_W          = 32;
    localparam int PITCH_W        = 16;
    localparam int SHIFT_W        = 5;
    localparam int COORD_W        = 16;
    localparam int COLOR_W        = 24;
    localparam int CLIP_W         = COORD_W + 3;
    localparam int IDX_W          = 3;
    localparam int CFG_W          = 32;
    localparam int S_TDATA_W      = 4 * COORD_W + COLOR_W;
    localparam int M_TDATA_W      = ADDR_W + PIX_W;

    // Input operation codes (tuser on the slave side).
    localparam logic OP_FILL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_FB_BASE       = 3'd0,
        REG_SCREEN_WIDTH  = 3'd1,
        REG_SCREEN_HEIGHT = 3'd2,
        REG_LINE_PITCH    = 3'd3,
        REG_FOUR_BYTE     = 3'd4,
        REG_RED_SHIFT     = 3'd5,
        REG_GREEN_SHIFT   = 3'd6,
        REG_BLUE_SHIFT    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  fb_base;
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [PITCH_W-1:0] line_pitch;
        logic               four_byte_pixels;
        logic [SHIFT_W-1:0] red_shift;
        logic [SHIFT_W-1:0] green_shift;
        logic [SHIFT_W-1:0] blue_shift;
    } cfg_t;

endpackage

### rtl/clipped_rect_fill_writer.sv
// Clipped rectangle fill writer. A fill item (tuser = 0) carries a signed
// rectangle and a 0xRRGGBB color; it is clipped to the screen (negative
// origins shrink the extent, the right and bottom edges cut it) and dropped
// when empty, when the screen width register is zero, or when a fill is
// still running. The color bytes are shifted to the configured channel
// positions (bits past 31 are lost). Each tick item (tuser = 1) during a fill
// yields one framebuffer write, row-major: address = fb_base + row*pitch +
// col*(4 or 3), wrapping at 32 bits, with tlast on the final pixel; ticks
// while idle yield nothing. Items pass an input register, then one compute
// stage (clip, or a 13x16 row*pitch multiply plus two adds) feeding the output
// register: one item per clock sustained while the output is not blocked.
// The input side keeps accepting while a result waits as long as the
// waiting item produces no result; only a blocked output stalls it.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user must do so only while idle (not enforced).
`include "assert_macros.svh"

module clipped_rect_fill_writer
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_wr_en,
    input  logic [crfw_pkg::IDX_W-1:0]           cfg_index,
    input  logic [crfw_pkg::CFG_W-1:0]           cfg_wdata,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48], fill_color[87:64]
    input  logic [crfw_pkg::S_TDATA_W-1:0]       s_tdata,
    // operation
    input  logic                                 s_tuser,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // write_address[31:0], write_data[63:32]
    output logic [crfw_pkg::M_TDATA_W-1:0]       m_tdata,
    // write_four
    output logic                                 m_tuser,
    // last_write
    output logic                                 m_tlast
);

    localparam int CW = crfw_pkg::CLIP_W;

    // Configuration registers
    crfw_pkg::cfg_t cfg_reg;

    // Input register
    logic                               in_valid_reg;
    logic                               in_op_reg;
    logic [crfw_pkg::S_TDATA_W-1:0]     in_data_reg;

    // Fill state
    logic                               busy_reg, busy_next;
    logic [crfw_pkg::COL_W-1:0]         col_reg, col_next;
    logic [crfw_pkg::COL_W-1:0]         row_reg, row_next;
    logic [crfw_pkg::COL_W-1:0]         first_col_reg, first_col_next;
    logic [crfw_pkg::END_W-1:0]         end_col_reg, end_col_next;
    logic [crfw_pkg::END_W-1:0]         end_row_reg, end_row_next;
    logic [crfw_pkg::PIX_W-1:0]         pixel_reg, pixel_next;

    // Output register
    logic                               out_valid_reg;
    logic [crfw_pkg::ADDR_W-1:0]        out_addr_reg;
    logic [crfw_pkg::PIX_W-1:0]         out_data_reg;
    logic                               out_four_reg;
    logic                               out_last_reg;

    logic produce, advance, out_free;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fb_base          <= '0;
            cfg_reg.screen_width     <= '0;
            cfg_reg.screen_height    <= '0;
            cfg_reg.line_pitch       <= '0;
            cfg_reg.four_byte_pixels <= 1'b1;
            cfg_reg.red_shift        <= crfw_pkg::SHIFT_W'(16);
            cfg_reg.green_shift      <= crfw_pkg::SHIFT_W'(8);
            cfg_reg.blue_shift       <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (crfw_pkg::reg_index_t'(cfg_index))
                crfw_pkg::REG_FB_BASE:
                    cfg_reg.fb_base <= cfg_wdata[crfw_pkg::ADDR_W-1:0];
                crfw_pkg::REG_SCREEN_WIDTH:
                    cfg_reg.screen_width <= cfg_wdata[crfw_pkg::DIM_W-1:0];
                crfw_pkg::REG_SCREEN_HEIGHT:
                    cfg_reg.screen_height <= cfg_wdata[crfw_pkg::DIM_W-1:0];
                crfw_pkg::REG_LINE_PITCH:
                    cfg_reg.line_pitch <= cfg_wdata[crfw_pkg::PITCH_W-1:0];
                crfw_pkg::REG_FOUR_BYTE:
                    cfg_reg.four_byte_pixels <= cfg_wdata[0];
                crfw_pkg::REG_RED_SHIFT:
                    cfg_reg.red_shift <= cfg_wdata[crfw_pkg::SHIFT_W-1:0];
                crfw_pkg::REG_GREEN_SHIFT:
                    cfg_reg.green_shift <= cfg_wdata[crfw_pkg::SHIFT_W-1:0];
                crfw_pkg::REG_BLUE_SHIFT:
                    cfg_reg.blue_shift <= cfg_wdata[crfw_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // A tick during a fill is the only item that needs the output register.
    assign produce  = in_valid_reg && (in_op_reg == crfw_pkg::OP_TICK) && busy_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!produce || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    // ---------------- clipping of a fill item ----------------
    logic signed [CW-1:0] x0, y0, w0, h0, sw, sh;
    logic signed [CW-1:0] x1, y1, w1, h1, w2, h2;
    logic                 empty;
    logic [7:0]           red, green, blue;
    logic [crfw_pkg::PIX_W-1:0] packed_color;

    always_comb
    begin
        x0 = CW'(signed'(in_data_reg[15:0]));
        y0 = CW'(signed'(in_data_reg[31:16]));
        w0 = CW'(signed'(in_data_reg[47:32]));
        h0 = CW'(signed'(in_data_reg[63:48]));
        // Screen sizes above the maximum are saturated for clipping.
        sw = (cfg_reg.screen_width > crfw_pkg::DIM_W'(crfw_pkg::MAX_SCREEN_DIM))
           ? CW'(crfw_pkg::MAX_SCREEN_DIM) : CW'(cfg_reg.screen_width);
        sh = (cfg_reg.screen_height > crfw_pkg::DIM_W'(crfw_pkg::MAX_SCREEN_DIM))
           ? CW'(crfw_pkg::MAX_SCREEN_DIM) : CW'(cfg_reg.screen_height);

        x1 = x0[CW-1] ? '0 : x0;
        w1 = x0[CW-1] ? w0 + x0 : w0;
        y1 = y0[CW-1] ? '0 : y0;
        h1 = y0[CW-1] ? h0 + y0 : h0;
        w2 = (x1 + w1 > sw) ? sw - x1 : w1;
        h2 = (y1 + h1 > sh) ? sh - y1 : h1;
        empty = w2[CW-1] || (w2 == '0) || h2[CW-1] || (h2 == '0);

        red   = in_data_reg[87:80];
        green = in_data_reg[79:72];
        blue  = in_data_reg[71:64];
        packed_color = (crfw_pkg::PIX_W'(red)   << cfg_reg.red_shift)
                     | (crfw_pkg::PIX_W'(green) << cfg_reg.green_shift)
                     | (crfw_pkg::PIX_W'(blue)  << cfg_reg.blue_shift);
    end

    // ---------------- tick: address and cursor step ----------------
    logic [crfw_pkg::COL_W+crfw_pkg::PITCH_W-1:0] row_offset;
    logic [crfw_pkg::COL_W+1:0]                   col_offset;
    logic [crfw_pkg::ADDR_W-1:0]                  tick_addr;
    logic [crfw_pkg::END_W-1:0]                   col_inc, row_inc;
    logic                                         tick_last;

    always_comb
    begin
        row_offset = row_reg * cfg_reg.line_pitch;
        col_offset = cfg_reg.four_byte_pixels
                   ? {col_reg, 2'b00}
                   : ({1'b0, col_reg, 1'b0} + (crfw_pkg::COL_W+2)'(col_reg));
        tick_addr  = cfg_reg.fb_base + crfw_pkg::ADDR_W'(row_offset)
                   + crfw_pkg::ADDR_W'(col_offset);
        col_inc    = crfw_pkg::END_W'(col_reg) + 1'b1;
        row_inc    = crfw_pkg::END_W'(row_reg) + 1'b1;
        tick_last  = (col_inc == end_col_reg) && (row_inc == end_row_reg);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        first_col_next = first_col_reg;
        end_col_next   = end_col_reg;
        end_row_next   = end_row_reg;
        pixel_next     = pixel_reg;
        if (advance)
        begin
            if (in_op_reg == crfw_pkg::OP_FILL)
            begin
                // Dropped while busy, with no display, or when clipped away.
                if (!busy_reg && (cfg_reg.screen_width != '0) && !empty)
                begin
                    busy_next      = 1'b1;
                    first_col_next = x1[crfw_pkg::COL_W-1:0];
                    col_next       = x1[crfw_pkg::COL_W-1:0];
                    row_next       = y1[crfw_pkg::COL_W-1:0];
                    end_col_next   = crfw_pkg::END_W'(x1 + w2);
                    end_row_next   = crfw_pkg::END_W'(y1 + h2);
                    pixel_next     = packed_color;
                end
            end
            else if (busy_reg)
            begin
                if (col_inc >= end_col_reg)
                begin
                    col_next = first_col_reg;
                    row_next = row_inc[crfw_pkg::COL_W-1:0];
                    if (row_inc >= end_row_reg)
                    begin
                        busy_next = 1'b0;
                    end
                end
                else
                begin
                    col_next = col_inc[crfw_pkg::COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            first_col_reg <= '0;
            end_col_reg   <= '0;
            end_row_reg   <= '0;
            pixel_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            first_col_reg <= first_col_next;
            end_col_reg   <= end_col_next;
            end_row_reg   <= end_row_next;
            pixel_reg     <= pixel_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_addr_reg <= tick_addr;
            out_data_reg <= pixel_reg;
            out_four_reg <= cfg_reg.four_byte_pixels;
            out_last_reg <= tick_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg, out_addr_reg};
    assign m_tuser  = out_four_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_cursor_in_bounds, clk, rst_n,
        busy_reg |-> (crfw_pkg::END_W'(col_reg) < end_col_reg)
                  && (crfw_pkg::END_W'(row_reg) < end_row_reg),
        "cursor outside the clipped rectangle")
    `ASSERT_CLK(a_last_ends_fill, clk, rst_n,
        (advance && produce && tick_last) |=> !busy_reg,
        "fill still running after its last write")
    `ASSERT_CLK(a_no_lost_result, clk, rst_n,
        (out_valid_reg && !m_tready) |-> !(advance && produce),
        "result overwritten while stalled")

endmodule
